// File: rtl/dntl_pkg.sv
// Shared types, constants and arithmetic helpers for the day/night terrain lighting core.
// No dependencies; used by every module under rtl/.
package dntl_pkg;

    localparam int unsigned MAP_SIZE = 128;

    localparam logic [11:0] CLOCK_RESET = 12'd1200;
    localparam logic [11:0] CLOCK_WRAP  = 12'd2400;
    localparam logic [11:0] SEG_LEN     = 12'd600;
    localparam logic [3:0]  BLEND_RESET = 4'd8;
    localparam logic [7:0]  AMBIENT_RESET = 8'd255;

    // Reciprocal of 75 for the divide by 600 (= 8 * 75), exact for dividends below 19200
    localparam logic [29:0] RECIP_75  = 30'd27963;
    // Reciprocal of 3, exact for 8-bit values
    localparam logic [15:0] RECIP_3   = 16'd171;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_SHADE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        SEG_DAWN      = 2'd0,
        SEG_MORNING   = 2'd1,
        SEG_AFTERNOON = 2'd2,
        SEG_DUSK      = 2'd3
    } seg_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // Input word payload, last field in the lowest bits
    typedef struct packed {
        logic [7:0]         world_blue;
        logic [7:0]         world_green;
        logic [7:0]         world_red;
        logic signed [15:0] height_along_y;
        logic signed [15:0] height_along_x;
        logic signed [15:0] height_here;
        logic signed [8:0]  tile_y;
        logic signed [8:0]  tile_x;
        logic               outside;
        logic               paused;
    } in_word_t;

    localparam int unsigned IN_BITS    = $bits(in_word_t);
    localparam int unsigned IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int unsigned TDATA_IN_W = IN_BYTES * 8;
    localparam int unsigned TDATA_OUT_W = $bits(rgb_t);

    // Interpolation numerator a*(600-i) + b*i, rewritten as a*600 +/- |b-a|*i
    function automatic logic [17:0] lerp_num(seg_t seg, chan_t ch, logic [9:0] i);
        logic [17:0] i18;
        logic [17:0] n;
        i18 = 18'(i);
        n   = '0;
        unique case (seg)
            SEG_DAWN: begin
                case (ch)
                    CH_RED:   n = 18'd38400 + i18 * 18'd158;
                    CH_GREEN: n = 18'd38400 + (i18 << 6);
                    CH_BLUE:  n = 18'd76800;
                    default:  n = '0;
                endcase
            end
            SEG_MORNING: begin
                case (ch)
                    CH_RED:   n = 18'd133200 + i18 * 18'd34;
                    CH_GREEN: n = 18'd76800 + (i18 << 7);
                    CH_BLUE:  n = 18'd76800 + (i18 << 7);
                    default:  n = '0;
                endcase
            end
            SEG_AFTERNOON: begin
                case (ch)
                    CH_RED:   n = 18'd153600 - i18 * 18'd34;
                    CH_GREEN: n = 18'd153600 - (i18 << 7);
                    CH_BLUE:  n = 18'd153600 - (i18 << 7);
                    default:  n = '0;
                endcase
            end
            SEG_DUSK: begin
                case (ch)
                    CH_RED:   n = 18'd133200 - i18 * 18'd158;
                    CH_GREEN: n = 18'd76800 - (i18 << 6);
                    CH_BLUE:  n = 18'd76800;
                    default:  n = '0;
                endcase
            end
        endcase
        return n;
    endfunction

    // n / 600: drop the factor 8, then multiply by the reciprocal of 75
    function automatic logic [8:0] div600(logic [17:0] n);
        logic [29:0] p;
        p = 30'(n[17:3]) * RECIP_75;
        return p[29:21];
    endfunction

    // Fade in eighths; codes 8 and above pass the value through
    function automatic logic [7:0] blend_scale(logic [7:0] v, logic [3:0] b);
        logic [7:0] p;
        p = {3'b000, v[7:3]} * {5'b00000, b[2:0]};
        return b[3] ? v : p;
    endfunction

    function automatic logic [6:0] third_of(logic [7:0] v);
        logic [15:0] p;
        p = {8'h00, v} * RECIP_3;
        return p[15:9];
    endfunction

endpackage

// File: rtl/dntl_ambient.sv
// Day clock advance and ambient color interpolation for one tick word.
// Depends on dntl_pkg.
module dntl_ambient (
    input  logic [11:0]         day_clock,
    input  logic                paused,
    input  logic                outside,
    input  logic [3:0]          blend_level,
    input  dntl_pkg::rgb_t      ambient_old,
    output logic [11:0]         day_clock_new,
    output dntl_pkg::rgb_t      ambient_new
);

    logic [11:0]        clk_inc;
    logic [11:0]        t;
    logic [11:0]        i_raw;
    logic [9:0]         i;
    dntl_pkg::seg_t     seg;
    logic [8:0]         q_red;
    logic [8:0]         q_green;
    logic [8:0]         q_blue;

    always_comb begin
        clk_inc       = paused ? day_clock : day_clock + 12'd1;
        day_clock_new = (clk_inc > dntl_pkg::CLOCK_WRAP) ? 12'd0 : clk_inc;
        t             = outside ? day_clock_new : 12'd0;

        priority if (t <= dntl_pkg::SEG_LEN) begin
            seg   = dntl_pkg::SEG_DAWN;
            i_raw = t;
        end else if (t <= 12'd1200) begin
            seg   = dntl_pkg::SEG_MORNING;
            i_raw = t - 12'd600;
        end else if (t <= 12'd1800) begin
            seg   = dntl_pkg::SEG_AFTERNOON;
            i_raw = t - 12'd1200;
        end else begin
            seg   = dntl_pkg::SEG_DUSK;
            i_raw = t - 12'd1800;
        end
        i = (i_raw > dntl_pkg::SEG_LEN) ? 10'd600 : i_raw[9:0];
    end

    assign q_red   = dntl_pkg::div600(dntl_pkg::lerp_num(seg, dntl_pkg::CH_RED, i));
    assign q_green = dntl_pkg::div600(dntl_pkg::lerp_num(seg, dntl_pkg::CH_GREEN, i));
    assign q_blue  = dntl_pkg::div600(dntl_pkg::lerp_num(seg, dntl_pkg::CH_BLUE, i));

    // 256 is out of range: keep the old channel, but the fade still applies
    always_comb begin
        ambient_new.red   = dntl_pkg::blend_scale(q_red[8]   ? ambient_old.red   : q_red[7:0],
                                                  blend_level);
        ambient_new.green = dntl_pkg::blend_scale(q_green[8] ? ambient_old.green : q_green[7:0],
                                                  blend_level);
        ambient_new.blue  = dntl_pkg::blend_scale(q_blue[8]  ? ambient_old.blue  : q_blue[7:0],
                                                  blend_level);
    end

endmodule

// File: rtl/dntl_shade.sv
// Terrain tile shading: ambient plus world light plus slope term, clamped and faded.
// Tiles off the map shade to zero. Depends on dntl_pkg.
module dntl_shade (
    input  dntl_pkg::rgb_t      ambient,
    input  logic                third_en,
    input  logic [3:0]          blend_level,
    input  logic signed [8:0]   tile_x,
    input  logic signed [8:0]   tile_y,
    input  logic signed [15:0]  height_here,
    input  logic signed [15:0]  height_along_x,
    input  logic signed [15:0]  height_along_y,
    input  dntl_pkg::rgb_t      world,
    output dntl_pkg::rgb_t      shade
);

    logic in_map;
    logic x_pos;
    logic x_neg;
    logic y_pos;
    logic y_neg;

    function automatic logic [7:0] shade_chan(logic [7:0] amb, logic [7:0] wld, logic te,
                                              logic xp, logic xn, logic yp, logic yn,
                                              logic [3:0] b);
        logic signed [10:0] th;
        logic signed [10:0] tx;
        logic signed [10:0] ty;
        logic signed [10:0] s;
        logic [7:0]         c;
        // slope thirds read as zero until the first tick has set them
        th = te ? signed'({4'b0000, dntl_pkg::third_of(amb)}) : 11'sd0;
        tx = xp ? th : (xn ? -th : 11'sd0);
        ty = yp ? th : (yn ? -th : 11'sd0);
        s  = signed'({3'b000, amb}) + signed'({3'b000, wld}) + tx + ty;
        priority if (s < 11'sd0) begin
            c = 8'd0;
        end else if (s > 11'sd255) begin
            c = 8'd255;
        end else begin
            c = s[7:0];
        end
        return dntl_pkg::blend_scale(c, b);
    endfunction

    always_comb begin
        in_map = !tile_x[8] && !tile_y[8]
              && (tile_x[7:0] < 8'(dntl_pkg::MAP_SIZE))
              && (tile_y[7:0] < 8'(dntl_pkg::MAP_SIZE));
        x_pos = height_here > height_along_x;
        x_neg = height_here < height_along_x;
        y_pos = height_here > height_along_y;
        y_neg = height_here < height_along_y;

        if (in_map) begin
            shade.red   = shade_chan(ambient.red, world.red, third_en,
                                     x_pos, x_neg, y_pos, y_neg, blend_level);
            shade.green = shade_chan(ambient.green, world.green, third_en,
                                     x_pos, x_neg, y_pos, y_neg, blend_level);
            shade.blue  = shade_chan(ambient.blue, world.blue, third_en,
                                     x_pos, x_neg, y_pos, y_neg, blend_level);
        end else begin
            shade = '0;
        end
    end

endmodule

// File: rtl/day_night_terrain_lighting_core.sv
// Day/night terrain lighting core, top level.
// An accepted input word goes through the input register and the result register to m_tvalid.
// Throughput: one word per cycle unless m_tready stalls; tick and shade datapaths each fit
// in the single stage between the registers; a tick updates the ambient state as it leaves.
// Reset (aresetn low, synchronous): day clock 1200, ambient 255/255/255, slope thirds zero
// until the first tick, blend level 8, empty. Depends on dntl_pkg, dntl_ambient, dntl_shade.
module day_night_terrain_lighting_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // cfg_wr_data: blend_level[3:0]
    input  logic                                cfg_wr_en,
    input  logic [3:0]                          cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: paused, outside, tile_x[8:0], tile_y[8:0], height_here[15:0],
    //          height_along_x[15:0], height_along_y[15:0], world_red, world_green,
    //          world_blue, zero pad
    input  logic [dntl_pkg::TDATA_IN_W-1:0]     s_tdata,
    // s_tuser: command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: red[7:0], green[7:0], blue[7:0]
    output logic [dntl_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    dntl_pkg::in_word_t     in_word_reg;
    dntl_pkg::cmd_t         in_cmd_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    dntl_pkg::rgb_t         out_rgb_reg;
    dntl_pkg::rgb_t         out_rgb_next;

    logic [11:0]            day_clock_reg;
    logic [11:0]            day_clock_next;
    dntl_pkg::rgb_t         ambient_reg;
    dntl_pkg::rgb_t         ambient_next;
    logic                   third_en_reg;
    logic                   third_en_next;
    logic [3:0]             blend_reg;

    logic                   out_ready;
    logic                   advance;
    logic [11:0]            tick_clock;
    dntl_pkg::rgb_t         tick_rgb;
    dntl_pkg::rgb_t         shade_rgb;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_rgb_reg;

    dntl_ambient u_ambient (
        .day_clock      (day_clock_reg),
        .paused         (in_word_reg.paused),
        .outside        (in_word_reg.outside),
        .blend_level    (blend_reg),
        .ambient_old    (ambient_reg),
        .day_clock_new  (tick_clock),
        .ambient_new    (tick_rgb)
    );

    dntl_shade u_shade (
        .ambient        (ambient_reg),
        .third_en       (third_en_reg),
        .blend_level    (blend_reg),
        .tile_x         (in_word_reg.tile_x),
        .tile_y         (in_word_reg.tile_y),
        .height_here    (in_word_reg.height_here),
        .height_along_x (in_word_reg.height_along_x),
        .height_along_y (in_word_reg.height_along_y),
        .world          ({in_word_reg.world_blue, in_word_reg.world_green,
                          in_word_reg.world_red}),
        .shade          (shade_rgb)
    );

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_rgb_next   = (in_cmd_reg == dntl_pkg::CMD_TICK) ? tick_rgb : shade_rgb;
        day_clock_next = day_clock_reg;
        ambient_next   = ambient_reg;
        third_en_next  = third_en_reg;
        // state moves only when a tick word leaves the input register
        if (advance && (in_cmd_reg == dntl_pkg::CMD_TICK)) begin
            day_clock_next = tick_clock;
            ambient_next   = tick_rgb;
            third_en_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            day_clock_reg <= dntl_pkg::CLOCK_RESET;
            ambient_reg   <= {dntl_pkg::AMBIENT_RESET, dntl_pkg::AMBIENT_RESET,
                              dntl_pkg::AMBIENT_RESET};
            third_en_reg  <= 1'b0;
            blend_reg     <= dntl_pkg::BLEND_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            day_clock_reg <= day_clock_next;
            ambient_reg   <= ambient_next;
            third_en_reg  <= third_en_next;
            if (cfg_wr_en) begin
                blend_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_word_reg <= dntl_pkg::in_word_t'(s_tdata[dntl_pkg::IN_BITS-1:0]);
            in_cmd_reg  <= dntl_pkg::cmd_t'(s_tuser);
        end
        if (advance) begin
            out_rgb_reg <= out_rgb_next;
        end
    end

endmodule
